// ----- src/cdb_pkg.sv -----
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared constants and types of the button matrix debouncer.
// ----------------------------------------------------------------------------
package cdb_pkg;

    localparam int NUM_BUTTONS   = 12;
    localparam int SENSE_W       = 3;
    localparam int SENSE_BUTTONS = 4 * SENSE_W;
    localparam int TIME_W        = 32;
    localparam int DEB_W         = 16;
    localparam int IDX_W         = 4;
    localparam int CELL_SEL_W    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd25;

    // One scan as it travels down the row of cells
    typedef struct packed {
        logic                   valid;
        logic [TIME_W-1:0]      now;
        logic [NUM_BUTTONS-1:0] raw;
        logic [NUM_BUTTONS-1:0] chg;
    } stage_t;

    // Control shared by every cell
    typedef struct packed {
        logic             advance;
        logic [DEB_W-1:0] debounce;
    } cell_ctl_t;

endpackage

// ----- src/cdb_cell.sv -----
// ----------------------------------------------------------------------------
// cdb_cell
// One button: holds its accepted level and last change time, decides on the
// scan passing by and hands the scan to the next cell.
// ----------------------------------------------------------------------------
module cdb_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cdb_pkg::cell_ctl_t               ctl,
    input  logic [cdb_pkg::CELL_SEL_W-1:0]   cell_idx,
    input  cdb_pkg::stage_t                  in_stage,
    output cdb_pkg::stage_t                  out_stage
);

    logic                        accepted_reg;
    logic [cdb_pkg::TIME_W-1:0]  change_time_reg;
    cdb_pkg::stage_t             stage_reg;
    cdb_pkg::stage_t             stage_next;
    logic                        want;
    logic                        take;
    logic [cdb_pkg::TIME_W-1:0]  elapsed;

    assign want    = in_stage.raw[cell_idx];
    // wraps modulo 2^32 by width
    assign elapsed = in_stage.now - change_time_reg;
    assign take    = in_stage.valid && (want != accepted_reg)
                     && (elapsed > cdb_pkg::TIME_W'(ctl.debounce));

    always_comb
    begin
        stage_next               = in_stage;
        stage_next.chg[cell_idx] = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg    <= 1'b0;
            change_time_reg <= '0;
            stage_reg       <= '0;
        end
        else if (ctl.advance)
        begin
            stage_reg <= stage_next;
            if (take)
            begin
                accepted_reg    <= want;
                change_time_reg <= in_stage.now;
            end
        end
    end

    assign out_stage = stage_reg;

endmodule

// ----- src/cdb_serializer.sv -----
// ----------------------------------------------------------------------------
// cdb_serializer
// Holds the change mask of one scan and emits one event per set bit, lowest
// button first, marking the final one.
// ----------------------------------------------------------------------------
module cdb_serializer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdb_pkg::stage_t               in_stage,
    input  logic                          out_ready,
    output logic                          load_ok,
    output logic                          out_valid,
    output logic [cdb_pkg::IDX_W-1:0]     out_index,
    output logic                          out_pressed,
    output logic                          out_last
);

    logic [cdb_pkg::NUM_BUTTONS-1:0] mask_reg;
    logic [cdb_pkg::NUM_BUTTONS-1:0] mask_next;
    logic [cdb_pkg::NUM_BUTTONS-1:0] raw_reg;
    logic [cdb_pkg::NUM_BUTTONS-1:0] raw_next;
    logic [cdb_pkg::NUM_BUTTONS-1:0] onehot;
    logic [cdb_pkg::NUM_BUTTONS-1:0] rest;
    logic                            pop;

    // isolate the lowest pending button
    assign onehot    = mask_reg & (~mask_reg + 1'b1);
    assign rest      = mask_reg & ~onehot;
    assign out_valid = |mask_reg;
    assign pop       = out_valid && out_ready;
    assign load_ok   = !out_valid || (pop && (rest == '0));
    assign out_last  = (rest == '0);
    assign out_pressed = |(onehot & raw_reg);

    always_comb
    begin
        out_index = '0;
        for (int i = 0; i < cdb_pkg::NUM_BUTTONS; i++)
        begin
            if (onehot[i])
            begin
                out_index = out_index | cdb_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        raw_next  = raw_reg;
        priority if (load_ok)
        begin
            mask_next = in_stage.valid ? in_stage.chg : '0;
            raw_next  = in_stage.raw;
        end
        else if (pop)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
    end

endmodule

// ----- src/charlieplex_button_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// charlieplex_button_debouncer_top
// Debouncer for a two-drive, three-sense button matrix with press/release
// events.
// ----------------------------------------------------------------------------
// A scan enters a row of twelve cells, one per button, and moves one cell per
// cycle while the row advances; each cell owns its button's accepted level and
// last change time, so scans follow each other every cycle unless stalled.
// After the row, a serializer emits a scan's events one per cycle while
// m_tready is high, lowest button first, with tlast on the final one. The row
// stalls while the serializer is busy and a scan waits at the row's end; a scan
// causing no event produces no output. The user must write debounce_ms through
// the cfg channel, always ready, only while idle; the block does not enforce it.
module charlieplex_button_debouncer_top (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: sense_drive1_low[2:0], sense_drive1_high[5:3],
    //          sense_drive2_low[8:6], sense_drive2_high[11:9], now_ms[43:12]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // m_tdata: button_index[3:0], pressed[4]; tlast is last_event
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [cdb_pkg::DEB_W-1:0]         debounce_reg;
    logic [cdb_pkg::SENSE_BUTTONS-1:0] sense_all;
    cdb_pkg::stage_t                   chain [cdb_pkg::NUM_BUTTONS+1];
    cdb_pkg::cell_ctl_t                ctl;
    logic                              load_ok;
    logic [cdb_pkg::IDX_W-1:0]         out_index;
    logic                              out_pressed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= cdb_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            debounce_reg <= cfg_data;
        end
    end

    // low-drive samples are active low
    assign sense_all = {s_tdata[11:9], ~s_tdata[8:6], s_tdata[5:3], ~s_tdata[2:0]};

    always_comb
    begin
        chain[0].valid = s_tvalid;
        chain[0].now   = s_tdata[43:12];
        chain[0].raw   = cdb_pkg::NUM_BUTTONS'(sense_all);
        chain[0].chg   = '0;
    end

    // the whole row moves together; hold while the serializer is busy and a scan waits at the row's end
    assign ctl.advance  = load_ok || !chain[cdb_pkg::NUM_BUTTONS].valid;
    assign ctl.debounce = debounce_reg;
    assign s_tready     = ctl.advance;

    for (genvar g = 0; g < cdb_pkg::NUM_BUTTONS; g++)
    begin : g_cell
        cdb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .cell_idx  (cdb_pkg::CELL_SEL_W'(g)),
            .in_stage  (chain[g]),
            .out_stage (chain[g+1])
        );
    end

    cdb_serializer u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_stage    (chain[cdb_pkg::NUM_BUTTONS]),
        .out_ready   (m_tready),
        .load_ok     (load_ok),
        .out_valid   (m_tvalid),
        .out_index   (out_index),
        .out_pressed (out_pressed),
        .out_last    (m_tlast)
    );

    assign m_tdata = {3'b000, out_pressed, out_index};

    // the row only stalls behind a scan waiting at its end
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> chain[cdb_pkg::NUM_BUTTONS].valid && m_tvalid)
        else $error("row stalled without a waiting scan");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_index < cdb_pkg::NUM_BUTTONS))
        else $error("event index out of range");

    // events of one scan follow without a gap in valid
    a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("scan events cut short");

endmodule
